[rtl/core/first_fit_allocator_coalescing_macros.svh]
// ----------------------------------------------------------------------------
// first_fit_allocator_coalescing_macros.svh
// Assertion macros shared by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_ALLOCATOR_COALESCING_MACROS_SVH
`define FIRST_FIT_ALLOCATOR_COALESCING_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define FFAC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define FFAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ffac_pkg.sv]
// ----------------------------------------------------------------------------
// ffac_pkg
// Types and fixed constants of the first-fit allocator.
// ----------------------------------------------------------------------------
package ffac_pkg;

    localparam int SIZE_W      = 13;
    localparam int OFFS_W      = 12;
    localparam int ALIGN_BYTES = 8;

    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } ffac_op_t;

    typedef enum logic [2:0]
    {
        ST_OK        = 3'd0,
        ST_BAD_SIZE  = 3'd1,
        ST_LOW_TOTAL = 3'd2,
        ST_NO_FIT    = 3'd3,
        ST_UNKNOWN   = 3'd4
    } ffac_status_t;

    typedef struct packed
    {
        ffac_op_t            operation;
        logic [SIZE_W-1:0]   request_size;
        logic [OFFS_W-1:0]   free_offset;
    } ffac_req_t;

    typedef struct packed
    {
        logic [OFFS_W-1:0]   block_offset;
        ffac_status_t        status;
    } ffac_rsp_t;

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_A_CK,
        S_A_APP,
        S_A_UPD,
        S_F_CK,
        S_M_CK,
        S_M_SET,
        S_C_NEXT,
        S_C_CK,
        S_D_RD,
        S_D_WR
    } ffac_state_t;

endpackage

[rtl/core/ffac_ram.sv]
// ----------------------------------------------------------------------------
// ffac_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ffac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/core/first_fit_allocator_coalescing.sv]
// ----------------------------------------------------------------------------
// first_fit_allocator_coalescing
// First-fit page allocator with free-chunk coalescing over a chunk table RAM.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken when start is high and busy is low. request
//   carries the operation (allocate or free), the size and the offset.
//   Exactly one result per transaction appears on result for one cycle,
//   flagged by done; the receiver must take it in that cycle.
//   Allocate with a bad size or a size above the free total shows its result
//   in the cycle right after the accepting edge, without raising busy.
//   Otherwise the block scans the chunk table in RAM, one entry per cycle,
//   then shifts entries down one per cycle when an entry is removed.
//   Free runs a lookup scan, a merge scan per folded entry and, after a
//   merge, a cascade pass from the last entry down.
//   The single-port-read table RAM sets the pace: one entry read per cycle.
//   A new transaction may start in the cycle a result is shown.
//   Reset leaves one free chunk spanning the whole page; no clearing pass.
// ----------------------------------------------------------------------------
module first_fit_allocator_coalescing #(
    parameter int PAGE_BYTES  = 4096,
    parameter int MAX_ENTRIES = 513
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ffac_pkg::ffac_req_t request,
    output logic              done,
    output ffac_pkg::ffac_rsp_t result
);

    import ffac_pkg::*;

    localparam int LW_PAGE = $clog2(PAGE_BYTES + 1);
    localparam int LW      = (LW_PAGE > SIZE_W) ? LW_PAGE : SIZE_W;
    localparam int IW      = $clog2(MAX_ENTRIES);
    localparam int CW      = $clog2(MAX_ENTRIES + 1);
    localparam int EW      = 2 * LW + 1;

    ffac_state_t      state_reg,   state_next;
    logic [CW-1:0]    count_reg,   count_next;
    logic [LW-1:0]    total_reg,   total_next;
    logic [CW-1:0]    idx_reg,     idx_next;
    logic [CW-1:0]    tgt_reg,     tgt_next;
    logic [CW-1:0]    cas_reg,     cas_next;
    logic [LW-1:0]    f_off_reg,   f_off_next;
    logic [LW-1:0]    f_len_reg,   f_len_next;
    logic [LW-1:0]    size_reg,    size_next;
    logic [LW-1:0]    foff_reg,    foff_next;
    logic [LW-1:0]    pos_reg,     pos_next;
    logic             casc_reg,    casc_next;
    logic             mode_reg,    mode_next;
    logic             init0_reg,   init0_next;
    logic             rdz_reg,     rdz_next;
    logic             done_reg,    done_next;
    ffac_rsp_t        rsp_reg,     rsp_next;

    logic             rd_en;
    logic [IW-1:0]    rd_addr;
    logic             we;
    logic [IW-1:0]    wr_addr;
    logic [EW-1:0]    wr_data;
    logic [EW-1:0]    ram_rdata;
    logic [EW-1:0]    ent;
    logic [LW-1:0]    r_off;
    logic [LW-1:0]    r_len;
    logic             r_free;
    logic [CW:0]      idx_inc;
    logic [CW:0]      idx_inc2;
    logic [CW-1:0]    cas_dec;
    logic [LW-1:0]    cmd_size;
    logic [LW:0]      r_end;
    logic [LW:0]      f_end;

    // Chunk table: {offset, length, free}
    ffac_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Entry 0 reads as the whole free page until first written
    assign ent    = (init0_reg && rdz_reg) ?
                    {LW'(0), LW'(PAGE_BYTES), 1'b1} : ram_rdata;
    assign r_off  = ent[EW-1 -: LW];
    assign r_len  = ent[LW:1];
    assign r_free = ent[0];

    assign idx_inc  = {1'b0, idx_reg} + (CW+1)'(1);
    assign idx_inc2 = {1'b0, idx_reg} + (CW+1)'(2);
    assign cas_dec  = cas_reg - CW'(1);
    assign cmd_size = LW'(request.request_size);
    assign r_end    = {1'b0, r_off} + {1'b0, r_len};
    assign f_end    = {1'b0, f_off_reg} + {1'b0, f_len_reg};

    // Control and status registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= CW'(1);
            total_reg <= LW'(PAGE_BYTES);
            casc_reg  <= 1'b0;
            mode_reg  <= 1'b0;
            init0_reg <= 1'b1;
            rdz_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            total_reg <= total_next;
            casc_reg  <= casc_next;
            mode_reg  <= mode_next;
            init0_reg <= init0_next;
            rdz_reg   <= rdz_next;
            done_reg  <= done_next;
        end
    end

    // Working payload registers
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        tgt_reg   <= tgt_next;
        cas_reg   <= cas_next;
        f_off_reg <= f_off_next;
        f_len_reg <= f_len_next;
        size_reg  <= size_next;
        foff_reg  <= foff_next;
        pos_reg   <= pos_next;
        rsp_reg   <= rsp_next;
    end

    // Next state, table accesses and result
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        total_next = total_reg;
        idx_next   = idx_reg;
        tgt_next   = tgt_reg;
        cas_next   = cas_reg;
        f_off_next = f_off_reg;
        f_len_next = f_len_reg;
        size_next  = size_reg;
        foff_next  = foff_reg;
        pos_next   = pos_reg;
        casc_next  = casc_reg;
        mode_next  = mode_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        we         = 1'b0;
        wr_addr    = '0;
        wr_data    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    size_next = cmd_size;
                    foff_next = LW'(request.free_offset);
                    idx_next  = '0;
                    if (request.operation == OP_ALLOC)
                    begin
                        if (cmd_size == '0 || (cmd_size % ALIGN_BYTES) != '0)
                        begin
                            done_next = 1'b1;
                            rsp_next  = '{block_offset: '0, status: ST_BAD_SIZE};
                        end
                        else if (cmd_size > total_reg)
                        begin
                            done_next = 1'b1;
                            rsp_next  = '{block_offset: '0, status: ST_LOW_TOTAL};
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            state_next = S_A_CK;
                        end
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        state_next = S_F_CK;
                    end
                end
            end

            // First-fit scan, one entry per cycle
            S_A_CK:
            begin
                if (r_free && r_len >= size_reg)
                begin
                    if (count_reg >= CW'(MAX_ENTRIES))
                    begin
                        done_next  = 1'b1;
                        rsp_next   = '{block_offset: '0, status: ST_NO_FIT};
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        tgt_next   = idx_reg;
                        f_off_next = r_off;
                        f_len_next = r_len;
                        state_next = S_A_APP;
                    end
                end
                else if (idx_inc >= {1'b0, count_reg})
                begin
                    done_next  = 1'b1;
                    rsp_next   = '{block_offset: '0, status: ST_NO_FIT};
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_inc[CW-1:0];
                    rd_en    = 1'b1;
                    rd_addr  = idx_inc[IW-1:0];
                end
            end

            // Append the allocated entry at the end of the table
            S_A_APP:
            begin
                pos_next   = f_off_reg + f_len_reg - size_reg;
                we         = 1'b1;
                wr_addr    = count_reg[IW-1:0];
                wr_data    = {pos_next, size_reg, 1'b0};
                count_next = count_reg + CW'(1);
                total_next = total_reg - size_reg;
                state_next = S_A_UPD;
            end

            // Shrink the source chunk, drop it when empty
            S_A_UPD:
            begin
                if (f_len_reg != size_reg)
                begin
                    we         = 1'b1;
                    wr_addr    = tgt_reg[IW-1:0];
                    wr_data    = {f_off_reg, LW'(f_len_reg - size_reg), 1'b1};
                    done_next  = 1'b1;
                    rsp_next   = '{block_offset: OFFS_W'(pos_reg), status: ST_OK};
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = tgt_reg;
                    mode_next  = 1'b0;
                    state_next = S_D_RD;
                end
            end

            // Lookup of the allocated entry to free
            S_F_CK:
            begin
                if (!r_free && r_off == foff_reg)
                begin
                    tgt_next   = idx_reg;
                    f_off_next = r_off;
                    f_len_next = r_len;
                    total_next = total_reg + r_len;
                    casc_next  = 1'b0;
                    mode_next  = 1'b1;
                    idx_next   = '0;
                    rd_en      = 1'b1;
                    state_next = S_M_CK;
                end
                else if (idx_inc >= {1'b0, count_reg})
                begin
                    done_next  = 1'b1;
                    rsp_next   = '{block_offset: '0, status: ST_UNKNOWN};
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_inc[CW-1:0];
                    rd_en    = 1'b1;
                    rd_addr  = idx_inc[IW-1:0];
                end
            end

            // Search for the first free neighbour of the held entry and merge the two
            S_M_CK:
            begin
                if (r_free && idx_reg != tgt_reg && r_end == {1'b0, f_off_reg})
                begin
                    we         = 1'b1;
                    wr_addr    = idx_reg[IW-1:0];
                    wr_data    = {r_off, LW'(r_len + f_len_reg), 1'b1};
                    idx_next   = tgt_reg;
                    state_next = S_D_RD;
                end
                else if (r_free && idx_reg != tgt_reg && f_end == {1'b0, r_off})
                begin
                    we         = 1'b1;
                    wr_addr    = idx_reg[IW-1:0];
                    wr_data    = {f_off_reg, LW'(r_len + f_len_reg), 1'b1};
                    idx_next   = tgt_reg;
                    state_next = S_D_RD;
                end
                else if (idx_inc >= {1'b0, count_reg})
                begin
                    if (!casc_reg)
                    begin
                        state_next = S_M_SET;
                    end
                    else
                    begin
                        cas_next   = cas_dec;
                        state_next = S_C_NEXT;
                    end
                end
                else
                begin
                    idx_next = idx_inc[CW-1:0];
                    rd_en    = 1'b1;
                    rd_addr  = idx_inc[IW-1:0];
                end
            end

            // No neighbour: only mark the entry free
            S_M_SET:
            begin
                we         = 1'b1;
                wr_addr    = tgt_reg[IW-1:0];
                wr_data    = {f_off_reg, f_len_reg, 1'b1};
                done_next  = 1'b1;
                rsp_next   = '{block_offset: '0, status: ST_OK};
                state_next = S_IDLE;
            end

            // Cascade walk from the last entry down
            S_C_NEXT:
            begin
                if (cas_reg == '0)
                begin
                    done_next  = 1'b1;
                    rsp_next   = '{block_offset: '0, status: ST_OK};
                    state_next = S_IDLE;
                end
                else if (cas_dec >= count_reg)
                begin
                    cas_next = cas_dec;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = cas_dec[IW-1:0];
                    state_next = S_C_CK;
                end
            end

            S_C_CK:
            begin
                if (r_free)
                begin
                    tgt_next   = cas_dec;
                    f_off_next = r_off;
                    f_len_next = r_len;
                    idx_next   = '0;
                    rd_en      = 1'b1;
                    state_next = S_M_CK;
                end
                else
                begin
                    cas_next   = cas_dec;
                    state_next = S_C_NEXT;
                end
            end

            // Remove entry idx: shift later entries down one per cycle
            S_D_RD, S_D_WR:
            begin
                if (state_reg == S_D_WR)
                begin
                    we       = 1'b1;
                    wr_addr  = idx_reg[IW-1:0];
                    wr_data  = ent;
                    idx_next = idx_inc[CW-1:0];
                end
                if ((state_reg == S_D_RD && idx_inc < {1'b0, count_reg}) ||
                    (state_reg == S_D_WR && idx_inc2 < {1'b0, count_reg}))
                begin
                    rd_en      = 1'b1;
                    rd_addr    = (state_reg == S_D_RD) ? idx_inc[IW-1:0] :
                                                         idx_inc2[IW-1:0];
                    state_next = S_D_WR;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    if (!mode_reg)
                    begin
                        done_next  = 1'b1;
                        rsp_next   = '{block_offset: OFFS_W'(pos_reg), status: ST_OK};
                        state_next = S_IDLE;
                    end
                    else if (!casc_reg)
                    begin
                        casc_next  = 1'b1;
                        cas_next   = count_next;
                        state_next = S_C_NEXT;
                    end
                    else
                    begin
                        cas_next   = cas_dec;
                        state_next = S_C_NEXT;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Track reads of entry 0 and its first write
    assign init0_next = init0_reg && !(we && wr_addr == '0);
    assign rdz_next   = rd_en ? (rd_addr == '0) : rdz_reg;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = rsp_reg;

`include "first_fit_allocator_coalescing_macros.svh"

    `FFAC_ASSERT_NOW(a_fail_zero_offset,
        done && result.status != ST_OK, result.block_offset == '0,
        "failed transaction reports nonzero offset")
    `FFAC_ASSERT_NOW(a_count_range,
        1'b1, count_reg != '0 && count_reg <= CW'(MAX_ENTRIES),
        "entry count out of range")
    `FFAC_ASSERT_NOW(a_total_range,
        1'b1, total_reg <= LW'(PAGE_BYTES),
        "free total above page size")
    `FFAC_ASSERT_NEXT(a_free_busy,
        start && !busy && request.operation == OP_FREE, busy && !done,
        "free transaction did not start a scan")

endmodule
